// ----- hdl/seek_steering_step_top_assert.svh -----
// Assertion macros shared by the seek steering step RTL.
`ifndef SEEK_STEERING_STEP_TOP_ASSERT_SVH
`define SEEK_STEERING_STEP_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sss_pkg.sv -----
// Package with the reset value, register indexes and sequencer states of the seek steering step.
package sss_pkg;
	localparam logic [23:0] GainReset = 24'd128000;

	typedef enum logic [1:0] {
		REG_GAIN = 2'd0,
		REG_FOLLOW = 2'd1,
		REG_TGT_X = 2'd2,
		REG_TGT_Y = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAG, ST_SQX, ST_SQY, ST_SQRT, ST_PRODX, ST_DIVX, ST_PRODY,
		ST_DIVY, ST_VELX, ST_VELY, ST_POSX, ST_POSY, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} unit_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [33:0] round_q16(input logic signed [49:0] p);
		logic signed [49:0] q;
		q = p + 50'sd32768;
		return 34'(q >>> 16);
	endfunction
endpackage

// ----- hdl/sss_iter.sv -----
// Shared iterative unit: 64-bit square root or 64-by-32 bit division, one bit per cycle.
module sss_iter (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic sqrt_mode,
	input logic [63:0] num,
	input logic [31:0] den,
	output logic [31:0] result,
	output sss_pkg::unit_ctl_t ctl
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [65:0] acc_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q, mode_q;
	logic [65:0] sq_acc;
	logic [65:0] sq_trial;
	logic [31:0] sq_root;
	logic [64:0] dv_acc;

	always_comb begin
		sq_acc = {acc_q[63:0], rem_q[63:62]};
		sq_root = quo_q[31:0];
		sq_trial = {32'd0, sq_root, 2'b01};
		dv_acc = {acc_q[63:0], rem_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mode_q <= sqrt_mode;
				cnt_q <= sqrt_mode ? 6'd31 : 6'd63;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mode_q) begin
				rem_q <= {rem_q[61:0], 2'b00};
				if (sq_acc >= sq_trial) begin
					acc_q <= sq_acc - sq_trial;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					acc_q <= sq_acc;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				rem_q <= {rem_q[62:0], 1'b0};
				if (dv_acc >= {33'd0, den}) begin
					acc_q <= {1'b0, dv_acc - {33'd0, den}};
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					acc_q <= {1'b0, dv_acc};
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	assign result = quo_q[31:0];
	assign ctl = '{start: start, busy: busy_q, done: done_q};

	`include "seek_steering_step_top_assert.svh"
	`SSS_ASSERT_NEXT(a_start_busy, start, busy_q, "unit not busy after start")
	`SSS_ASSERT_IMP(a_no_restart, busy_q, !start, "unit restarted while busy")
	`SSS_ASSERT_IMP(a_done_idle, done_q, !busy_q, "done while busy")
endmodule

// ----- hdl/seek_steering_step_top.sv -----
// Top level of the seek steering step: sequencer, registers and stream ports.
// Usage: an input transaction on s_axis (target x/y, position x/y, time step)
// starts one steering update. The block then runs a sequencer that uses one
// shared iterative unit for the offset length square root and for the two
// scaling divisions, plus multipliers for the squares, the gain scaling and
// the two time-step integrations. Both divisions are skipped when the offset
// is zero. s_axis_tready stays low while an item is in flight and returns the
// cycle after the result transaction, so no new item is accepted before the
// last result has been taken. The result carries new position, new velocity
// and the facing, which is the velocity held before the update. If the
// receiver stalls, the result holds stable on m_axis and no new item is
// accepted.
// Configuration writes use the cfg channel (index, data) and are always
// accepted; they must be made only while no item is in flight.
// Reset clears the velocity state, loads the register defaults
// (gain 128000, follow tracked target, fixed target at the origin) and leaves
// the block idle and ready.
module seek_steering_step_top (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: target_x[31:0], target_y[63:32], pos_x[95:64], pos_y[127:96], time_step[143:128]
	input logic [143:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: new_pos_x, new_pos_y, vel_x, vel_y, facing_x, facing_y, 32 bits each from bit 0
	output logic [191:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	sss_pkg::state_t state_q, state_d;
	logic [23:0] gain_q;
	logic follow_q;
	logic signed [31:0] ftx_q, fty_q, velx_q, vely_q;
	logic signed [31:0] px_q, py_q, facx_q, facy_q, nvx_q, nvy_q, npx_q;
	logic signed [32:0] dx_q, dy_q;
	logic [31:0] ax_q, ay_q, len_q, qx_q;
	logic [15:0] dt_q;
	logic [63:0] sum_q, prod_q;
	logic [191:0] out_q;
	logic in_acc;
	logic unit_start, unit_sqrt;
	logic [63:0] unit_num;
	logic [31:0] unit_res;
	sss_pkg::unit_ctl_t unit_ctl;
	logic signed [31:0] tgx, tgy;
	logic [32:0] mx, my;
	logic signed [33:0] wx, wy, stx, sty;
	logic signed [49:0] mp_vx, mp_vy, mp_px, mp_py;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == sss_pkg::ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == sss_pkg::ST_OUT);
	assign m_axis_tdata = out_q;

	always_comb begin
		tgx = follow_q ? $signed(s_axis_tdata[31:0]) : ftx_q;
		tgy = follow_q ? $signed(s_axis_tdata[63:32]) : fty_q;
		mx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
		my = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
		wx = dx_q[32] ? -$signed({2'b00, qx_q}) : $signed({2'b00, qx_q});
		wy = dy_q[32] ? -$signed({2'b00, unit_res}) : $signed({2'b00, unit_res});
		stx = wx - 34'(velx_q);
		sty = wy - 34'(vely_q);
		mp_vx = stx * $signed({1'b0, dt_q});
		mp_vy = sty * $signed({1'b0, dt_q});
		mp_px = 50'(nvx_q) * $signed({1'b0, dt_q});
		mp_py = 50'(nvy_q) * $signed({1'b0, dt_q});
	end

	always_comb begin
		state_d = state_q;
		unit_start = 1'b0;
		unit_sqrt = 1'b0;
		unit_num = sum_q;
		case (state_q)
			sss_pkg::ST_IDLE: if (in_acc) state_d = sss_pkg::ST_MAG;
			sss_pkg::ST_MAG: state_d = sss_pkg::ST_SQX;
			sss_pkg::ST_SQX: state_d = sss_pkg::ST_SQY;
			sss_pkg::ST_SQY: state_d = sss_pkg::ST_SQRT;
			sss_pkg::ST_SQRT: begin
				if (!unit_ctl.busy && !unit_ctl.done) begin
					unit_start = 1'b1;
					unit_sqrt = 1'b1;
				end
				if (unit_ctl.done) state_d = sss_pkg::ST_PRODX;
			end
			sss_pkg::ST_PRODX: state_d = (len_q == 32'd0) ? sss_pkg::ST_VELX : sss_pkg::ST_DIVX;
			sss_pkg::ST_DIVX: begin
				unit_num = prod_q;
				if (!unit_ctl.busy && !unit_ctl.done) unit_start = 1'b1;
				if (unit_ctl.done) state_d = sss_pkg::ST_PRODY;
			end
			sss_pkg::ST_PRODY: state_d = sss_pkg::ST_DIVY;
			sss_pkg::ST_DIVY: begin
				unit_num = prod_q;
				if (!unit_ctl.busy && !unit_ctl.done) unit_start = 1'b1;
				if (unit_ctl.done) state_d = sss_pkg::ST_VELX;
			end
			sss_pkg::ST_VELX: state_d = sss_pkg::ST_VELY;
			sss_pkg::ST_VELY: state_d = sss_pkg::ST_POSX;
			sss_pkg::ST_POSX: state_d = sss_pkg::ST_POSY;
			sss_pkg::ST_POSY: state_d = sss_pkg::ST_OUT;
			sss_pkg::ST_OUT: if (m_axis_tready) state_d = sss_pkg::ST_IDLE;
			default: state_d = sss_pkg::ST_IDLE;
		endcase
	end

	sss_iter u_iter (
		.clk(clk), .arst_n(arst_n), .start(unit_start), .sqrt_mode(unit_sqrt),
		.num(unit_num), .den(len_q), .result(unit_res), .ctl(unit_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sss_pkg::ST_IDLE;
			gain_q <= sss_pkg::GainReset;
			follow_q <= 1'b1;
			ftx_q <= '0;
			fty_q <= '0;
			velx_q <= '0;
			vely_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sss_pkg::REG_GAIN: gain_q <= cfg_data[23:0];
					sss_pkg::REG_FOLLOW: follow_q <= cfg_data[0];
					sss_pkg::REG_TGT_X: ftx_q <= cfg_data;
					sss_pkg::REG_TGT_Y: fty_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == sss_pkg::ST_POSY) begin
				velx_q <= nvx_q;
				vely_q <= nvy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sss_pkg::ST_IDLE: if (in_acc) begin
				px_q <= $signed(s_axis_tdata[95:64]);
				py_q <= $signed(s_axis_tdata[127:96]);
				dt_q <= s_axis_tdata[143:128];
				dx_q <= 33'(tgx) - 33'($signed(s_axis_tdata[95:64]));
				dy_q <= 33'(tgy) - 33'($signed(s_axis_tdata[127:96]));
				facx_q <= velx_q;
				facy_q <= vely_q;
				qx_q <= '0;
			end
			sss_pkg::ST_MAG: begin
				if (mx[32] || my[32] || mx[31] || my[31]) begin
					ax_q <= mx[32:1];
					ay_q <= my[32:1];
				end else begin
					ax_q <= mx[31:0];
					ay_q <= my[31:0];
				end
			end
			sss_pkg::ST_SQX: sum_q <= ax_q * ax_q;
			sss_pkg::ST_SQY: sum_q <= sum_q + ay_q * ay_q;
			sss_pkg::ST_SQRT: if (unit_ctl.done) len_q <= unit_res;
			sss_pkg::ST_PRODX: prod_q <= ax_q * {8'd0, gain_q};
			sss_pkg::ST_DIVX: if (unit_ctl.done) qx_q <= unit_res;
			sss_pkg::ST_PRODY: prod_q <= ay_q * {8'd0, gain_q};
			sss_pkg::ST_VELX: nvx_q <= sss_pkg::sat32(34'(velx_q) + sss_pkg::round_q16(mp_vx));
			sss_pkg::ST_VELY: nvy_q <= sss_pkg::sat32(34'(vely_q) + sss_pkg::round_q16(mp_vy));
			sss_pkg::ST_POSX: npx_q <= sss_pkg::sat32(34'(px_q) + sss_pkg::round_q16(mp_px));
			sss_pkg::ST_POSY: begin
				out_q <= {facy_q, facx_q, nvy_q, nvx_q,
					sss_pkg::sat32(34'(py_q) + sss_pkg::round_q16(mp_py)), npx_q};
			end
			sss_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	`include "seek_steering_step_top_assert.svh"
	`SSS_ASSERT_IMP(a_ready_idle, s_axis_tready, !m_axis_tvalid, "ready while result pending")
	`SSS_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
	`SSS_ASSERT_NEXT(a_vel_update, state_q == sss_pkg::ST_POSY, velx_q == $past(nvx_q), "velocity not stored")
endmodule

// ----- tb/seek_steering_step_top_test.sv -----
// Self-checking testbench for the seek steering step: a steering predictor with directed and random ticks.
`timescale 1ns / 100ps

module seek_steering_step_top_test;
	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] face_x;
		logic signed [31:0] face_y;
	} motion_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	motion_t motion_q[$];
	int unsigned error_count;
	bit calm;
	int unsigned stall_left;

	logic [23:0] gain_reg;
	logic follow_reg;
	longint fixed_x;
	longint fixed_y;
	longint cur_vx;
	longint cur_vy;

	seek_steering_step_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > n) probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_dt(input longint p);
		return (p + 64'sd32768) >>> 16;
	endfunction

	function automatic motion_t advance_agent(input logic signed [31:0] tx,
			input logic signed [31:0] ty, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic [15:0] dt);
		motion_t m;
		longint dx, dy, wx, wy, nvx, nvy, step;
		longint unsigned ax, ay, len;
		step = longint'(dt);
		if (follow_reg) begin
			dx = longint'(tx) - longint'(px);
			dy = longint'(ty) - longint'(py);
		end else begin
			dx = fixed_x - longint'(px);
			dy = fixed_y - longint'(py);
		end
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		wx = 0;
		wy = 0;
		if (len != 0) begin
			wx = longint'((ax * gain_reg) / len);
			wy = longint'((ay * gain_reg) / len);
			if (dx < 0) wx = -wx;
			if (dy < 0) wy = -wy;
		end
		nvx = clamp32(cur_vx + scale_dt((wx - cur_vx) * step));
		nvy = clamp32(cur_vy + scale_dt((wy - cur_vy) * step));
		m.face_x = cur_vx[31:0];
		m.face_y = cur_vy[31:0];
		m.vel_x = nvx[31:0];
		m.vel_y = nvy[31:0];
		m.pos_x = 32'(clamp32(longint'(px) + scale_dt(nvx * step)));
		m.pos_y = 32'(clamp32(longint'(py) + scale_dt(nvy * step)));
		cur_vx = nvx;
		cur_vy = nvy;
		return m;
	endfunction

	task automatic send_tick(input logic [31:0] tx, input logic [31:0] ty,
			input logic [31:0] px, input logic [31:0] py, input logic [15:0] dt);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dt, py, px, ty, tx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		motion_q.push_back(advance_agent(tx, ty, px, py, dt));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input sss_pkg::reg_idx_t idx, input logic [31:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			sss_pkg::REG_GAIN: gain_reg = value[23:0];
			sss_pkg::REG_FOLLOW: follow_reg = value[0];
			sss_pkg::REG_TGT_X: fixed_x = longint'(signed'(value));
			sss_pkg::REG_TGT_Y: fixed_y = longint'(signed'(value));
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		int unsigned next_stall;
		next_stall = stall_left;
		if (next_stall != 0) next_stall--;
		else if (!calm && $urandom_range(0, 5) == 0) next_stall = $urandom_range(1, 13);
		stall_left <= next_stall;
		m_axis_tready <= arst_n && next_stall == 0;
	end

	always @(posedge clk) begin
		motion_t e;
		logic [191:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (motion_q.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				e = motion_q.pop_front();
				want = {e.face_y, e.face_x, e.vel_y, e.vel_x, e.pos_y, e.pos_x};
				for (int f = 0; f < 6; f++) begin
					if (m_axis_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
						$display("%0t: field %0d expected %h actual %h", $time, f,
							want[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
						error_count++;
					end
				end
			end
		end
	end

	task automatic test_defaults();
		send_tick(32'h0000_6400, 32'h0000_3200, 32'd0, 32'd0, 16'h1000);
		send_tick(32'h0000_6400, 32'h0000_3200, 32'h0000_0100, 32'd0, 16'h1000);
		send_tick(32'd0, 32'd0, 32'd0, 32'd0, 16'h4000);
		send_tick(32'h0000_0500, 32'hffff_f000, 32'h0000_0500, 32'hffff_f000, 16'hffff);
		send_tick(32'h0000_0a00, 32'h0000_0a00, 32'd0, 32'd0, 16'h0000);
	endtask

	task automatic test_extremes();
		send_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'hffff);
		send_tick(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
		send_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ff00, 32'h7fff_fff0, 16'hffff);
		send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0010, 32'h8000_0100, 16'hffff);
		send_tick(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
		send_tick(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h8000);
	endtask

	task automatic test_gain_and_fixed_target();
		write_reg(sss_pkg::REG_GAIN, 32'hff00_0000);
		send_tick(32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 16'hffff);
		write_reg(sss_pkg::REG_GAIN, 32'hffff_ffff);
		send_tick(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'd0, 16'hffff);
		send_tick(32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ff00, 32'd0, 16'hffff);
		send_tick(32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ff00, 32'd0, 16'hffff);
		write_reg(sss_pkg::REG_FOLLOW, 32'hffff_fffe);
		write_reg(sss_pkg::REG_TGT_X, 32'h7fff_ffff);
		write_reg(sss_pkg::REG_TGT_Y, 32'h8000_0000);
		send_tick(32'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
		send_tick(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff, 32'h8000_0000, 16'h2000);
		write_reg(sss_pkg::REG_GAIN, 32'h0000_0100);
		write_reg(sss_pkg::REG_TGT_X, 32'hffff_f000);
		write_reg(sss_pkg::REG_TGT_Y, 32'h0000_3000);
		send_tick(32'd0, 32'd0, 32'd0, 32'd0, 16'h7fff);
		write_reg(sss_pkg::REG_FOLLOW, 32'd1);
	endtask

	task automatic test_random();
		logic [31:0] tx, ty, px, py;
		logic [15:0] dt;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_reg(sss_pkg::REG_GAIN, 32'd128000);
				1: write_reg(sss_pkg::REG_GAIN, $urandom);
				2: write_reg(sss_pkg::REG_FOLLOW, 32'd0);
				3: write_reg(sss_pkg::REG_TGT_X, $urandom);
				4: write_reg(sss_pkg::REG_FOLLOW, 32'd1);
				default: write_reg(sss_pkg::REG_GAIN, $urandom_range(0, 4096));
			endcase
			if (phase == 5) calm = 1'b1;
			px = $urandom_range(0, 65535) - 32768;
			py = $urandom_range(0, 65535) - 32768;
			for (int n = 0; n < 165; n++) begin
				if ($urandom_range(0, 7) == 0) begin
					tx = $urandom;
					ty = $urandom;
					px = $urandom;
					py = $urandom;
					dt = 16'($urandom);
				end else begin
					tx = px + $urandom_range(0, 131071) - 65536;
					ty = py + $urandom_range(0, 131071) - 65536;
					dt = 16'($urandom_range(0, 4000));
				end
				send_tick(tx, ty, px, py, dt);
				px = motion_q[motion_q.size() - 1].pos_x;
				py = motion_q[motion_q.size() - 1].pos_y;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sss_pkg::REG_GAIN;
		cfg_data = '0;
		error_count = 0;
		calm = 1'b0;
		stall_left = 0;
		gain_reg = sss_pkg::GainReset;
		follow_reg = 1'b1;
		fixed_x = 0;
		fixed_y = 0;
		cur_vx = 0;
		cur_vy = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_gain_and_fixed_target();
		test_random();
		wait_idle();
		repeat (200) @(posedge clk);
		if (error_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/sss_pkg.sv
hdl/sss_iter.sv
hdl/seek_steering_step_top.sv
tb/seek_steering_step_top_test.sv
